[rtl/dsmm_pkg.sv]
// ----------------------------------------------------------------------------
// dsmm_pkg: shared types and constants for the 2x2 downsampler
// Holds the line buffer geometry, register indexes, combine modes and the
// pair and block combining functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dsmm_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int PAIR_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W     = $clog2(PAIR_DEPTH);
  localparam int PIX_W      = 16;
  localparam int COL_W      = 13;
  localparam int SLOT_W     = COL_W - 1;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_SAMPLE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_AVG = 2'd0,
    MODE_MIN = 2'd1,
    MODE_MAX = 2'd2
  } mode_t;

  typedef logic [PIX_W-1:0] pix_t;

  // Combines the two pixels of one row of a block. Code 3 acts as maximum.
  function automatic pix_t pair_pick(input pix_t a, input pix_t b, input logic [1:0] mode);
    pix_t res;
    unique case (mode)
      MODE_AVG: res = (a >> 2) + (b >> 2);
      MODE_MIN: res = (a <= b) ? a : b;
      default:  res = (a >= b) ? a : b;
    endcase
    return res;
  endfunction

  // Combines the stored upper-row partial with the lower-row pair value.
  // The average sum wraps at 16 bits.
  function automatic pix_t block_merge(input pix_t p, input pix_t q, input logic [1:0] mode);
    pix_t res;
    unique case (mode)
      MODE_AVG: res = p + q;
      MODE_MIN: res = (p <= q) ? p : q;
      default:  res = (p >= q) ? p : q;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/dsmm_ram.sv]
// ----------------------------------------------------------------------------
// dsmm_ram: generic simple dual-port RAM
// One write port and one read port with a registered read that updates
// only when the read is enabled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dsmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/downsample_2x2_avg_min_max.sv]
// ----------------------------------------------------------------------------
// downsample_2x2_avg_min_max: 2x2 image downsampler (average, min, max)
// Halves a raster image in both directions using a line buffer of partials.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the in_ channel in row order, one per transfer, with
//   in_frame_start marking the first pixel of a frame. Results leave on the
//   out_ channel, one per 2x2 block, with out_line_end on the last block of
//   an output row. The cfg_ channel writes mode, line width and sample size
//   and is always ready; write it only while the block is idle.
//   Throughput is one pixel per cycle while in_ready is high. The line
//   buffer is a RAM with one write and one read port: even rows write
//   one partial per column pair, odd rows read it back, so each pixel
//   needs at most one RAM access. The odd-column pixel that completes a
//   block reads the RAM and fills the merge stage; the merge then writes
//   the output register, which raises out_valid.
//   When the receiver stalls, the output register holds the result, one more
//   result waits in the merge stage, and in_ready falls only when both are
//   full. Reset (rst_n low, synchronous) clears position, held pixel, the
//   pipeline and the registers (mode average, width 4096, 8-bit samples).
//   The line buffer needs no clearing: every partial is written before read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module downsample_2x2_avg_min_max (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [dsmm_pkg::PIX_W-1:0] in_pixel,
  input  wire logic                      in_frame_start,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic      [dsmm_pkg::PIX_W-1:0] out_pixel,
  output logic                           out_line_end,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [dsmm_pkg::COL_W-1:0] cfg_data
);

  import dsmm_pkg::*;

  // Configuration registers.
  logic [1:0]       mode_r;
  logic [COL_W-1:0] line_width_r;
  logic             sample16_r;

  // Position state.
  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_odd_r, row_odd_nxt;
  pix_t             held_r, held_nxt;

  // Merge stage and output register.
  logic             s1_v_r, s1_v_nxt;
  pix_t             s1_pv_r;
  logic             s1_last_r;
  logic             out_valid_r, out_valid_nxt;
  pix_t             out_pixel_r;
  logic             out_last_r;

  logic             in_acc;
  logic             s1_adv;
  logic [COL_W-1:0] width_eff;
  logic [SLOT_W-1:0] pairs;
  logic [COL_W-1:0] col_cur;
  logic             row_cur;
  logic [SLOT_W-1:0] slot;
  logic             slot_ok;
  logic [COL_W-1:0] col_inc;
  pix_t             sample;
  pix_t             pair_val;
  logic             ram_wr, ram_rd;
  pix_t             ram_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_AVG;
      line_width_r <= COL_W'(MAX_WIDTH);
      sample16_r   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:   mode_r       <= cfg_data[1:0];
        REG_WIDTH:  line_width_r <= cfg_data;
        REG_SAMPLE: sample16_r   <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    if (line_width_r < COL_W'(2)) begin
      width_eff = COL_W'(2);
    end else if (32'(line_width_r) > MAX_WIDTH) begin
      width_eff = COL_W'(MAX_WIDTH);
    end else begin
      width_eff = line_width_r;
    end
    pairs = width_eff[COL_W-1:1];

    // A frame start puts this pixel at column 0 of an even row.
    col_cur = in_frame_start ? '0 : col_r;
    row_cur = in_frame_start ? 1'b0 : row_odd_r;
    slot    = col_cur[COL_W-1:1];
    slot_ok = (slot < pairs) && (32'(slot) < PAIR_DEPTH);

    sample   = sample16_r ? in_pixel : {8'd0, in_pixel[7:0]};
    pair_val = pair_pick(held_r, sample, mode_r);

    ram_wr = in_acc && col_cur[0] && slot_ok && !row_cur;
    ram_rd = in_acc && col_cur[0] && slot_ok && row_cur;

    col_inc     = col_cur + COL_W'(1);
    col_nxt     = col_r;
    row_odd_nxt = row_odd_r;
    held_nxt    = held_r;
    if (in_acc) begin
      if (!col_cur[0]) begin
        held_nxt = sample;
      end
      if (col_inc >= width_eff || col_inc == '0) begin
        col_nxt     = '0;
        row_odd_nxt = !row_cur;
      end else begin
        col_nxt     = col_inc;
        row_odd_nxt = row_cur;
      end
    end

    s1_v_nxt = s1_v_r;
    if (ram_rd) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  dsmm_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PAIR_DEPTH)
  ) u_line_buf (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (slot[ADDR_W-1:0]),
    .wr_data (pair_val),
    .rd_en   (ram_rd),
    .rd_addr (slot[ADDR_W-1:0]),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_odd_r   <= 1'b0;
      held_r      <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      col_r       <= col_nxt;
      row_odd_r   <= row_odd_nxt;
      held_r      <= held_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_rd) begin
      s1_pv_r   <= pair_val;
      s1_last_r <= (slot + SLOT_W'(1)) == pairs;
    end
    if (s1_adv) begin
      out_pixel_r <= block_merge(ram_q, s1_pv_r, mode_r);
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel    = out_pixel_r;
  assign out_line_end = out_last_r;

  // The line buffer is never written and read by the same pixel.
  a_ram_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_wr && ram_rd))
    else $error("line buffer written and read in one cycle");

  // Input stalls only when both the merge stage and the output are full.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_v_r && out_valid_r))
    else $error("input stalled without a full pipeline");

  // A stalled merge stage keeps its result.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s1_adv) |=> s1_v_r)
    else $error("merge stage result lost");

  // A frame start lands the next pixel at column 1 of an even row.
  a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_frame_start) |=> (col_r == COL_W'(1) && !row_odd_r))
    else $error("frame start did not restart the position");

endmodule

`default_nettype wire
